>>> rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg: shared types and constants of the line follower PID step
// Field widths, codes, sensor weights and the frame record that travels
// from the classifier through the queue to the control back end.
// ----------------------------------------------------------------------------
package lfps_pkg;

   localparam int SENSOR_COUNT = 7;
   localparam int QUEUE_DEPTH  = 2;

   localparam int MS_W     = 8;
   localparam int ERR_W    = 5;
   localparam int INTEG_W  = 7;
   localparam int D_W      = 6;
   localparam int TIMER_W  = 10;
   localparam int GAIN_W   = 16;
   localparam int SPEED_W  = 8;
   localparam int DRIVE_W  = 9;
   localparam int ACTION_W = 3;
   localparam int FRAC_W   = 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // sensor positions, bit 0 rightmost
   localparam int S_RIGHT_END = 0;
   localparam int S_RIGHT_IN  = 1;
   localparam int S_CENTRE    = 3;
   localparam int S_LEFT_IN   = 5;
   localparam int S_LEFT_END  = 6;

   localparam logic signed [ERR_W-1:0] WEIGHTS [SENSOR_COUNT] =
      '{5'sd5, 5'sd4, 5'sd3, 5'sd0, -5'sd3, -5'sd4, -5'sd5};

   localparam int INTEG_MAX    = 50;
   localparam int TURN_TIMEOUT = 700;
   localparam int TIMER_MAX    = 1023;
   localparam int DRIVE_MAX    = 255;

   localparam logic signed [DRIVE_W-1:0] DRV_TURN_FWD = 9'sd150;
   localparam logic signed [DRIVE_W-1:0] DRV_TURN_REV = -9'sd100;
   localparam logic signed [DRIVE_W-1:0] DRV_SPIN_FWD = 9'sd150;
   localparam logic signed [DRIVE_W-1:0] DRV_SPIN_REV = -9'sd150;

   localparam logic signed [ERR_W-1:0] ERR_SHARP = 5'sd3;

   localparam logic [GAIN_W-1:0]  GAIN_PROP_RST  = 16'd7168;
   localparam logic [GAIN_W-1:0]  GAIN_INTEG_RST = 16'd5;
   localparam logic [GAIN_W-1:0]  GAIN_DERIV_RST = 16'd9984;
   localparam logic [SPEED_W-1:0] SPEED_LOW_RST  = 8'd120;
   localparam logic [SPEED_W-1:0] SPEED_HIGH_RST = 8'd200;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GAIN_PROP  = 3'd0,
      CSR_GAIN_INTEG = 3'd1,
      CSR_GAIN_DERIV = 3'd2,
      CSR_SPEED_LOW  = 3'd3,
      CSR_SPEED_HIGH = 3'd4
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PID    = 3'd0,
      ACT_CROSS  = 3'd1,
      ACT_TURN_R = 3'd2,
      ACT_TURN_L = 3'd3,
      ACT_SPIN_R = 3'd4,
      ACT_SPIN_L = 3'd5
   } action_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_prop;
      logic [GAIN_W-1:0]  gain_integ;
      logic [GAIN_W-1:0]  gain_deriv;
      logic [SPEED_W-1:0] speed_low;
      logic [SPEED_W-1:0] speed_high;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic                    active;
      logic                    centre;
      action_type              ovr;
      logic [MS_W-1:0]         ms;
   } frame_type;

endpackage

>>> rtl/lfps_front.sv
// ----------------------------------------------------------------------------
// lfps_front: sensor frame classifier
// Normalizes line polarity, forms the weighted error and picks the override.
// ----------------------------------------------------------------------------
module lfps_front (
   input  logic [lfps_pkg::SENSOR_COUNT-1:0] line_bits,
   input  logic [lfps_pkg::MS_W-1:0]         elapsed_ms,
   output lfps_pkg::frame_type               frame
);

   localparam int ONES_W = $clog2(lfps_pkg::SENSOR_COUNT + 1);

   logic [ONES_W-1:0]                    ones;
   logic [lfps_pkg::SENSOR_COUNT-1:0]    s;
   logic signed [lfps_pkg::ERR_W-1:0]    err;

   always_comb begin
      ones = '0;
      for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
         ones = ones + ONES_W'(line_bits[i]);
      end
      // invert a mostly-set frame so the line always reads as set bits
      s = (ones < ONES_W'((lfps_pkg::SENSOR_COUNT + 1) / 2)) ? line_bits : ~line_bits;
      err = '0;
      for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
         if (s[i]) begin
            err = err + lfps_pkg::WEIGHTS[i];
         end
      end
   end

   always_comb begin
      frame.err    = err;
      frame.active = |s;
      frame.centre = s[lfps_pkg::S_CENTRE];
      frame.ms     = elapsed_ms;
      if (s[lfps_pkg::S_CENTRE] && (s[lfps_pkg::S_RIGHT_END] || s[lfps_pkg::S_LEFT_END])) begin
         frame.ovr = lfps_pkg::ACT_CROSS;
      end else if (s[lfps_pkg::S_LEFT_END] && !s[lfps_pkg::S_LEFT_IN]) begin
         frame.ovr = lfps_pkg::ACT_TURN_R;
      end else if (s[lfps_pkg::S_RIGHT_END] && !s[lfps_pkg::S_RIGHT_IN]) begin
         frame.ovr = lfps_pkg::ACT_TURN_L;
      end else if (s[lfps_pkg::S_RIGHT_END] && s[lfps_pkg::S_RIGHT_IN]
                   && !s[lfps_pkg::S_CENTRE]) begin
         frame.ovr = lfps_pkg::ACT_SPIN_R;
      end else if (s[lfps_pkg::S_LEFT_END] && s[lfps_pkg::S_LEFT_IN]
                   && !s[lfps_pkg::S_CENTRE]) begin
         frame.ovr = lfps_pkg::ACT_SPIN_L;
      end else begin
         frame.ovr = lfps_pkg::ACT_PID;
      end
   end

endmodule

>>> rtl/lfps_queue.sv
// ----------------------------------------------------------------------------
// lfps_queue: short frame queue
// Decouples the classifier from the control back end.
// ----------------------------------------------------------------------------
module lfps_queue #(
   parameter int DEPTH = lfps_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lfps_pkg::frame_type push_frame,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output lfps_pkg::frame_type head_frame
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lfps_pkg::frame_type mem_ff [DEPTH];
   logic [IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_frame = mem_ff[rd_ptr_ff];

endmodule

>>> rtl/lfps_back.sv
// ----------------------------------------------------------------------------
// lfps_back: control back end
// Holds the loop state, runs the PID in three stages and drives the result.
// ----------------------------------------------------------------------------
module lfps_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lfps_pkg::cfg_type                      cfg,
   input  logic                                   head_valid,
   input  lfps_pkg::frame_type                    head_frame,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [lfps_pkg::DRIVE_W-1:0]    rsp_left,
   output logic signed [lfps_pkg::DRIVE_W-1:0]    rsp_right,
   output lfps_pkg::action_type                   rsp_action
);

   localparam int ERR_W   = lfps_pkg::ERR_W;
   localparam int INTEG_W = lfps_pkg::INTEG_W;
   localparam int D_W     = lfps_pkg::D_W;
   localparam int TIMER_W = lfps_pkg::TIMER_W;
   localparam int SPEED_W = lfps_pkg::SPEED_W;
   localparam int DRIVE_W = lfps_pkg::DRIVE_W;
   localparam int FRAC_W  = lfps_pkg::FRAC_W;
   localparam int GS_W    = lfps_pkg::GAIN_W + 1;
   localparam int P_W     = GS_W + ERR_W;
   localparam int I_W     = GS_W + INTEG_W;
   localparam int DV_W    = GS_W + D_W;
   localparam int SUM_W   = I_W + 1;
   localparam int PID_W   = SUM_W - FRAC_W;
   localparam int WIDE_W  = PID_W + 1;

   typedef enum logic [1:0] {
      MODE_FOLLOW = 2'd0,
      MODE_TURN_R = 2'd1,
      MODE_TURN_L = 2'd2
   } mode_type;

   // loop state
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [INTEG_W-1:0] integ_sum_ff;
   mode_type                  turn_mode_ff;
   logic [TIMER_W-1:0]        turn_timer_ff;

   // stage 1
   logic                      s1_valid_ff;
   lfps_pkg::action_type      s1_act_ff, s1_act_in;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [INTEG_W-1:0] s1_integ_ff;
   logic signed [D_W-1:0]     s1_d_ff;
   logic [SPEED_W-1:0]        s1_base_ff, s1_base_in;

   // stage 2
   logic                      s2_valid_ff;
   lfps_pkg::action_type      s2_act_ff;
   logic [SPEED_W-1:0]        s2_base_ff;
   logic signed [P_W-1:0]     s2_prop_ff, s2_prop_in;
   logic signed [I_W-1:0]     s2_integ_ff, s2_integ_in;
   logic signed [DV_W-1:0]    s2_deriv_ff, s2_deriv_in;

   // output register
   logic                           rsp_valid_ff;
   logic signed [DRIVE_W-1:0]      rsp_left_ff, rsp_left_in;
   logic signed [DRIVE_W-1:0]      rsp_right_ff, rsp_right_in;
   lfps_pkg::action_type           rsp_action_ff;

   logic                      advance;
   logic                      turning;
   logic [TIMER_W:0]          timer_sum;
   logic [TIMER_W-1:0]        timer_sat;
   logic                      turn_done;
   logic signed [ERR_W-1:0]   err;
   logic signed [INTEG_W:0]   integ_wide;
   logic signed [INTEG_W-1:0] integ_new;
   logic signed [D_W-1:0]     d;
   logic [SPEED_W:0]          speed_sum;
   logic                      err_le1, err_le3, d_le1;

   logic signed [SUM_W-1:0]   pid_sum, pid_adj;
   logic [SUM_W-1:0]          pid_bias;
   logic signed [PID_W-1:0]   pid;
   logic signed [WIDE_W-1:0]  base_w, left_raw, right_raw;

   function automatic logic signed [DRIVE_W-1:0] clamp_drive(
      input logic signed [WIDE_W-1:0] v
   );
      logic signed [DRIVE_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > WIDE_W'(lfps_pkg::DRIVE_MAX)) begin
         r = DRIVE_W'(lfps_pkg::DRIVE_MAX);
      end else begin
         r = v[DRIVE_W-1:0];
      end
      return r;
   endfunction

   // the whole pipeline moves when the output register is free or drained
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && head_valid;

   // stage 1: loop state, error, integral, derivative, base speed
   always_comb begin
      // the unused mode code acts as following
      turning    = turn_mode_ff inside {MODE_TURN_R, MODE_TURN_L};
      timer_sum  = {1'b0, turn_timer_ff} + (TIMER_W + 1)'(head_frame.ms);
      timer_sat  = (timer_sum > (TIMER_W + 1)'(lfps_pkg::TIMER_MAX))
                   ? TIMER_W'(lfps_pkg::TIMER_MAX) : timer_sum[TIMER_W-1:0];
      turn_done  = head_frame.centre || (timer_sat > TIMER_W'(lfps_pkg::TURN_TIMEOUT));
      err        = head_frame.active ? head_frame.err : last_err_ff;
      integ_wide = (INTEG_W + 1)'(integ_sum_ff) + (INTEG_W + 1)'(err);
      if (integ_wide > (INTEG_W + 1)'(lfps_pkg::INTEG_MAX)) begin
         integ_new = INTEG_W'(lfps_pkg::INTEG_MAX);
      end else if (integ_wide < -(INTEG_W + 1)'(lfps_pkg::INTEG_MAX)) begin
         integ_new = -INTEG_W'(lfps_pkg::INTEG_MAX);
      end else begin
         integ_new = integ_wide[INTEG_W-1:0];
      end
      d         = D_W'(err) - D_W'(last_err_ff);
      err_le1   = (err >= -5'sd1) && (err <= 5'sd1);
      err_le3   = (err >= -5'sd3) && (err <= 5'sd3);
      d_le1     = (d >= -6'sd1) && (d <= 6'sd1);
      speed_sum = (SPEED_W + 1)'(cfg.speed_high) + (SPEED_W + 1)'(cfg.speed_low);
      if (err_le1 && d_le1) begin
         s1_base_in = cfg.speed_high;
      end else if (err_le3) begin
         s1_base_in = speed_sum[SPEED_W:1];
      end else begin
         s1_base_in = cfg.speed_low;
      end
      if (!turning) begin
         s1_act_in = head_frame.ovr;
      end else if (turn_mode_ff == MODE_TURN_R) begin
         s1_act_in = lfps_pkg::ACT_TURN_R;
      end else begin
         s1_act_in = lfps_pkg::ACT_TURN_L;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff   <= '0;
         integ_sum_ff  <= '0;
         turn_mode_ff  <= MODE_FOLLOW;
         turn_timer_ff <= '0;
      end else if (pop) begin
         if (turning) begin
            turn_timer_ff <= timer_sat;
            if (turn_done) begin
               turn_mode_ff <= MODE_FOLLOW;
            end
         end else begin
            integ_sum_ff <= integ_new;
            case (head_frame.ovr)
               lfps_pkg::ACT_CROSS: begin
                  last_err_ff  <= '0;
                  turn_mode_ff <= MODE_FOLLOW;
               end
               lfps_pkg::ACT_TURN_R: begin
                  last_err_ff   <= -lfps_pkg::ERR_SHARP;
                  turn_mode_ff  <= MODE_TURN_R;
                  turn_timer_ff <= '0;
               end
               lfps_pkg::ACT_TURN_L: begin
                  last_err_ff   <= lfps_pkg::ERR_SHARP;
                  turn_mode_ff  <= MODE_TURN_L;
                  turn_timer_ff <= '0;
               end
               lfps_pkg::ACT_SPIN_R: begin
                  last_err_ff  <= lfps_pkg::ERR_SHARP;
                  turn_mode_ff <= MODE_FOLLOW;
               end
               lfps_pkg::ACT_SPIN_L: begin
                  last_err_ff  <= -lfps_pkg::ERR_SHARP;
                  turn_mode_ff <= MODE_FOLLOW;
               end
               default: begin
                  last_err_ff  <= err;
                  turn_mode_ff <= MODE_FOLLOW;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_act_ff   <= s1_act_in;
         s1_err_ff   <= err;
         s1_integ_ff <= integ_new;
         s1_d_ff     <= d;
         s1_base_ff  <= s1_base_in;
      end
   end

   // stage 2: the three gain products
   always_comb begin
      s2_prop_in  = P_W'($signed({1'b0, cfg.gain_prop})) * P_W'(s1_err_ff);
      s2_integ_in = I_W'($signed({1'b0, cfg.gain_integ})) * I_W'(s1_integ_ff);
      s2_deriv_in = DV_W'($signed({1'b0, cfg.gain_deriv})) * DV_W'(s1_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_act_ff   <= s1_act_ff;
         s2_base_ff  <= s1_base_ff;
         s2_prop_ff  <= s2_prop_in;
         s2_integ_ff <= s2_integ_in;
         s2_deriv_ff <= s2_deriv_in;
      end
   end

   // stage 3: sum, scale toward zero, clamp, pick the drive pair
   always_comb begin
      pid_sum   = SUM_W'(s2_prop_ff) + SUM_W'(s2_integ_ff) + SUM_W'(s2_deriv_ff);
      pid_bias  = pid_sum[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : '0;
      pid_adj   = pid_sum + $signed(pid_bias);
      pid       = pid_adj[SUM_W-1:FRAC_W];
      base_w    = $signed(WIDE_W'(s2_base_ff));
      left_raw  = base_w - WIDE_W'(pid);
      right_raw = base_w + WIDE_W'(pid);
      case (s2_act_ff)
         lfps_pkg::ACT_CROSS: begin
            rsp_left_in  = $signed(DRIVE_W'(cfg.speed_high));
            rsp_right_in = $signed(DRIVE_W'(cfg.speed_high));
         end
         lfps_pkg::ACT_TURN_R: begin
            rsp_left_in  = lfps_pkg::DRV_TURN_FWD;
            rsp_right_in = lfps_pkg::DRV_TURN_REV;
         end
         lfps_pkg::ACT_TURN_L: begin
            rsp_left_in  = lfps_pkg::DRV_TURN_REV;
            rsp_right_in = lfps_pkg::DRV_TURN_FWD;
         end
         lfps_pkg::ACT_SPIN_R: begin
            rsp_left_in  = lfps_pkg::DRV_SPIN_FWD;
            rsp_right_in = lfps_pkg::DRV_SPIN_REV;
         end
         lfps_pkg::ACT_SPIN_L: begin
            rsp_left_in  = lfps_pkg::DRV_SPIN_REV;
            rsp_right_in = lfps_pkg::DRV_SPIN_FWD;
         end
         default: begin
            rsp_left_in  = clamp_drive(left_raw);
            rsp_right_in = clamp_drive(right_raw);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_left_ff   <= rsp_left_in;
         rsp_right_ff  <= rsp_right_in;
         rsp_action_ff <= s2_act_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_left   = rsp_left_ff;
   assign rsp_right  = rsp_right_ff;
   assign rsp_action = rsp_action_ff;

   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_sum_ff <= 7'sd50) && (integ_sum_ff >= -7'sd50))
      else $error("integral left its clamp range");

   a_last_err_range: assert property (@(posedge clock) disable iff (reset)
      (last_err_ff <= 5'sd12) && (last_err_ff >= -5'sd12))
      else $error("stored error out of range");

   a_pid_drive_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_action_ff == lfps_pkg::ACT_PID)
      |-> !rsp_left_ff[DRIVE_W-1] && !rsp_right_ff[DRIVE_W-1])
      else $error("PID drive escaped the 0..255 clamp");

   a_turn_entry: assert property (@(posedge clock) disable iff (reset)
      pop && !turning && (head_frame.ovr == lfps_pkg::ACT_TURN_R)
      |=> (turn_mode_ff == MODE_TURN_R) && (turn_timer_ff == '0))
      else $error("sharp right turn not entered");

   a_turning_action: assert property (@(posedge clock) disable iff (reset)
      pop && (turn_mode_ff == MODE_TURN_L) |=> (s1_act_ff == lfps_pkg::ACT_TURN_L))
      else $error("turning frame lost its turn action");

endmodule

>>> rtl/line_follower_pid_step.sv
// ----------------------------------------------------------------------------
// line_follower_pid_step: one control step of a seven-sensor line follower
// Frame classifier, frame queue and a pipelined PID back end with overrides.
// ----------------------------------------------------------------------------
// Usage:
//   Send one sensor frame per word on the req_ stream: thresholded line bits
//   and the milliseconds since the previous frame. Each word yields exactly
//   one rsp_ word: signed left/right drives and the action taken.
//   Gains and speeds sit behind the csr_ write port; write them only while
//   no word is in flight.
// Pipeline: an accepted word passes the queue, then the state and error
//   stage, product stage, sum and clamp stage into the output register.
// Throughput: one word per cycle while the output is not stalled, set by the
//   loop state update (error, integral clamp, turn timer) in the first stage.
// Reset: clears the loop state (stored error, integral, turn mode and timer),
//   empties the queue and the pipeline and reloads the default gains and speeds.
// Stall: when rsp_tvalid is high and rsp_tready is low the output register
//   and pipeline hold; the queue takes words until full, then req_tready drops.
// ----------------------------------------------------------------------------
module line_follower_pid_step #(
   parameter int QUEUE_DEPTH = lfps_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // line_bits[6:0], elapsed_ms[14:7]
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [23:0]                        rsp_tdata,   // left_drive[8:0], right_drive[17:9]
   output logic [lfps_pkg::ACTION_W-1:0]      rsp_tuser,   // action[2:0]
   // register writes
   input  logic                               csr_we,
   input  logic [lfps_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [lfps_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SC    = lfps_pkg::SENSOR_COUNT;
   localparam int MS_W  = lfps_pkg::MS_W;
   localparam int DRV_W = lfps_pkg::DRIVE_W;

   lfps_pkg::cfg_type   cfg_ff;
   lfps_pkg::frame_type front_frame;
   lfps_pkg::frame_type head_frame;
   logic                q_full;
   logic                q_head_valid;
   logic                q_pop;
   logic                push;

   logic signed [DRV_W-1:0] rsp_left;
   logic signed [DRV_W-1:0] rsp_right;
   lfps_pkg::action_type    rsp_action;

   // register file: unknown indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_prop  <= lfps_pkg::GAIN_PROP_RST;
         cfg_ff.gain_integ <= lfps_pkg::GAIN_INTEG_RST;
         cfg_ff.gain_deriv <= lfps_pkg::GAIN_DERIV_RST;
         cfg_ff.speed_low  <= lfps_pkg::SPEED_LOW_RST;
         cfg_ff.speed_high <= lfps_pkg::SPEED_HIGH_RST;
      end else if (csr_we) begin
         case (csr_addr)
            lfps_pkg::CSR_GAIN_PROP:  cfg_ff.gain_prop  <= csr_wdata;
            lfps_pkg::CSR_GAIN_INTEG: cfg_ff.gain_integ <= csr_wdata;
            lfps_pkg::CSR_GAIN_DERIV: cfg_ff.gain_deriv <= csr_wdata;
            lfps_pkg::CSR_SPEED_LOW:  cfg_ff.speed_low  <= csr_wdata[lfps_pkg::SPEED_W-1:0];
            lfps_pkg::CSR_SPEED_HIGH: cfg_ff.speed_high <= csr_wdata[lfps_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // accept whenever the queue has room
   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;

   lfps_front u_front (
      .line_bits  (req_tdata[SC-1:0]),
      .elapsed_ms (req_tdata[SC+MS_W-1:SC]),
      .frame      (front_frame)
   );

   lfps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (front_frame),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_frame (head_frame)
   );

   lfps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_head_valid),
      .head_frame (head_frame),
      .pop        (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_left   (rsp_left),
      .rsp_right  (rsp_right),
      .rsp_action (rsp_action)
   );

   // pack the word: left drive low, right drive above, zero fill
   assign rsp_tdata = {{(24 - 2 * DRV_W){1'b0}}, rsp_right, rsp_left};
   assign rsp_tuser = rsp_action;

endmodule

>>> test/line_follower_pid_step_tb.sv
// ----------------------------------------------------------------------------
// line_follower_pid_step_tb: self-checking bench for the line follower step
// Streams sensor frames through the block, predicts each drive word in a
// scoreboard that keeps its own copy of the loop state and registers, and
// compares every result word field by field. Gains and speeds are reloaded
// between phases while the block is idle, covering zero, full-scale and
// default settings. Sender gaps and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module line_follower_pid_step_tb;

   import lfps_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;     // margin after the last expected word
   localparam int PHASE_FRAMES = 190;

   // first register index that maps to nothing
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_FIRST = CSR_ADDR_W'(CSR_SPEED_HIGH + 1);

   // sensor weights, bit 0 (rightmost) first
   localparam int STEER_WEIGHT [SENSOR_COUNT] = '{5, 4, 3, 0, -3, -4, -5};

   localparam int TURN_FWD = 150;
   localparam int TURN_REV = -100;
   localparam int SPIN_FWD = 150;
   localparam int SPIN_REV = -150;

   typedef enum logic [1:0] {
      STEER_FOLLOW     = 2'd0,
      STEER_TURN_RIGHT = 2'd1,
      STEER_TURN_LEFT  = 2'd2
   } steer_mode_type;

   typedef enum logic [1:0] {
      RX_OPEN   = 2'd0,
      RX_RANDOM = 2'd1,
      RX_SPARSE = 2'd2,
      RX_BLOCKS = 2'd3
   } rx_pattern_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] left;
      logic signed [DRIVE_W-1:0] right;
      action_type                act;
   } drive_word_type;

   // -------------------------------------------------------------------------
   // Drive predictor and store of expected drive words
   // -------------------------------------------------------------------------
   class drive_scoreboard;
      int             kp, ki, kd, speed_lo, speed_hi;
      int             prev_err, integ, turn_ms;
      steer_mode_type mode;
      drive_word_type expected_drives [$];
      int             mismatch_count;

      function new();
         kp             = 7168;
         ki             = 5;
         kd             = 9984;
         speed_lo       = 120;
         speed_hi       = 200;
         prev_err       = 0;
         integ          = 0;
         turn_ms        = 0;
         mode           = STEER_FOLLOW;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction

      function int clip(input int v, input int lo, input int hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function int magnitude(input int v);
         return (v < 0) ? -v : v;
      endfunction

      function void write_reg(input logic [CSR_ADDR_W-1:0] addr,
                              input logic [CSR_DATA_W-1:0] data);
         case (addr)
            CSR_GAIN_PROP:  kp       = int'(data);
            CSR_GAIN_INTEG: ki       = int'(data);
            CSR_GAIN_DERIV: kd       = int'(data);
            CSR_SPEED_LOW:  speed_lo = int'(data[SPEED_W-1:0]);
            CSR_SPEED_HIGH: speed_hi = int'(data[SPEED_W-1:0]);
            default: ;
         endcase
      endfunction

      // Advance the loop state by one frame and queue the drive word it gives.
      function void note_frame(input logic [SENSOR_COUNT-1:0] raw,
                               input logic [MS_W-1:0] ms);
         logic [SENSOR_COUNT-1:0] s;
         int             err, active, d, base, sum, pid, l, r;
         drive_word_type w;

         // a mostly-set frame means a light line on dark ground: flip it
         s = ($countones(raw) < 4) ? raw : ~raw;

         if (mode == STEER_TURN_RIGHT || mode == STEER_TURN_LEFT) begin
            turn_ms = clip(turn_ms + int'(ms), 0, TIMER_MAX);
            if (mode == STEER_TURN_RIGHT) begin
               w.left  = DRIVE_W'(TURN_FWD);
               w.right = DRIVE_W'(TURN_REV);
               w.act   = ACT_TURN_R;
            end else begin
               w.left  = DRIVE_W'(TURN_REV);
               w.right = DRIVE_W'(TURN_FWD);
               w.act   = ACT_TURN_L;
            end
            if (s[S_CENTRE] || turn_ms > TURN_TIMEOUT)
               mode = STEER_FOLLOW;
            expected_drives.push_back(w);
            return;
         end
         mode = STEER_FOLLOW;

         err    = 0;
         active = 0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (s[i]) begin
               err += STEER_WEIGHT[i];
               active++;
            end
         end
         // line lost: hold the last known error
         if (active == 0)
            err = prev_err;
         integ = clip(integ + err, -INTEG_MAX, INTEG_MAX);
         d     = err - prev_err;

         if (magnitude(err) <= 1 && magnitude(d) <= 1)
            base = speed_hi;
         else if (magnitude(err) <= 3)
            base = (speed_hi + speed_lo) / 2;
         else
            base = speed_lo;

         // Q8.8 gains; signed division truncates toward zero
         sum      = kp * err + ki * integ + kd * d;
         pid      = sum / 256;
         prev_err = err;
         l        = clip(base - pid, 0, DRIVE_MAX);
         r        = clip(base + pid, 0, DRIVE_MAX);

         if (s[S_CENTRE] && (s[S_RIGHT_END] || s[S_LEFT_END])) begin
            w.left   = DRIVE_W'(speed_hi);
            w.right  = DRIVE_W'(speed_hi);
            w.act    = ACT_CROSS;
            prev_err = 0;
         end else if (s[S_LEFT_END] && !s[S_LEFT_IN]) begin
            w.left   = DRIVE_W'(TURN_FWD);
            w.right  = DRIVE_W'(TURN_REV);
            w.act    = ACT_TURN_R;
            prev_err = -3;
            mode     = STEER_TURN_RIGHT;
            turn_ms  = 0;
         end else if (s[S_RIGHT_END] && !s[S_RIGHT_IN]) begin
            w.left   = DRIVE_W'(TURN_REV);
            w.right  = DRIVE_W'(TURN_FWD);
            w.act    = ACT_TURN_L;
            prev_err = 3;
            mode     = STEER_TURN_LEFT;
            turn_ms  = 0;
         end else if (s[S_RIGHT_END] && s[S_RIGHT_IN] && !s[S_CENTRE]) begin
            w.left   = DRIVE_W'(SPIN_FWD);
            w.right  = DRIVE_W'(SPIN_REV);
            w.act    = ACT_SPIN_R;
            prev_err = 3;
         end else if (s[S_LEFT_END] && s[S_LEFT_IN] && !s[S_CENTRE]) begin
            w.left   = DRIVE_W'(SPIN_REV);
            w.right  = DRIVE_W'(SPIN_FWD);
            w.act    = ACT_SPIN_L;
            prev_err = -3;
         end else begin
            w.left  = DRIVE_W'(l);
            w.right = DRIVE_W'(r);
            w.act   = ACT_PID;
         end
         expected_drives.push_back(w);
      endfunction

      function void check_word(input logic signed [DRIVE_W-1:0] left,
                               input logic signed [DRIVE_W-1:0] right,
                               input logic [ACTION_W-1:0] act);
         drive_word_type want;
         if (expected_drives.size() == 0) begin
            $error("drive word with none expected: left %0d right %0d action %0d",
                   left, right, act);
            mismatch_count++;
            return;
         end
         want = expected_drives.pop_front();
         if (left !== want.left) begin
            $error("left_drive: expected %0d, actual %0d", want.left, left);
            mismatch_count++;
         end
         if (right !== want.right) begin
            $error("right_drive: expected %0d, actual %0d", want.right, right);
            mismatch_count++;
         end
         if (act !== want.act) begin
            $error("action: expected %0d, actual %0d", want.act, act);
            mismatch_count++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // line_bits[6:0], elapsed_ms[14:7]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;         // left_drive[8:0], right_drive[17:9]
   logic [ACTION_W-1:0]   rsp_tuser;         // action[2:0]
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   drive_scoreboard board;
   int              burst_left  = 0;
   int              rx_span     = 0;
   rx_pattern_type  rx_pattern  = RX_OPEN;
   int              cycle_count = 0;

   line_follower_pid_step uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: note every accepted frame, check every accepted drive word.
   // A result always trails its frame through the queue and the pipeline
   // registers, so the order of the two handshakes within one edge does not matter.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_frame(req_tdata[6:0], req_tdata[14:7]);
         if (rsp_tvalid && rsp_tready)
            board.check_word(rsp_tdata[8:0], rsp_tdata[17:9], rsp_tuser);
      end
   end

   // Receiver: switch between stall patterns over randomly drawn spans so that
   // back-pressure lands on every pipeline stage, with open stretches too.
   always @(posedge clock) begin
      if (rx_span == 0) begin
         rx_span    = $urandom_range(16, 96);
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
      end
      rx_span--;
      case (rx_pattern)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_span % 4 == 0);
         default:   rsp_tready <= (rx_span % 16) < 8;
      endcase
   end

   // Watchdog: give up well past the slowest legal run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("line_follower_pid_step_tb: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------

   // Present one frame and hold it until accepted. Bursts of random length
   // are separated by random gaps; valid stays high inside a burst.
   task automatic send_frame(input logic [SENSOR_COUNT-1:0] line,
                             input logic [MS_W-1:0] ms);
      int gap;
      if (burst_left == 0) begin
         // now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, ms, line};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every expected word has come back, plus a
   // margin for anything spurious still in the pipeline.
   task automatic drain_words();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(addr, data);
   endtask

   // Reload all registers while idle. The write to an unmapped index goes
   // last so that any aliasing onto a real register would stick.
   task automatic load_settings(input int kp, input int ki, input int kd,
                                input int lo, input int hi);
      drain_words();
      write_reg(CSR_GAIN_PROP,  CSR_DATA_W'(kp));
      write_reg(CSR_GAIN_INTEG, CSR_DATA_W'(ki));
      write_reg(CSR_GAIN_DERIV, CSR_DATA_W'(kd));
      write_reg(CSR_SPEED_LOW,  CSR_DATA_W'(lo));
      write_reg(CSR_SPEED_HIGH, CSR_DATA_W'(hi));
      write_reg(CSR_ADDR_W'(CSR_UNUSED_FIRST +
                $urandom_range(0, (1 << CSR_ADDR_W) - 1 - CSR_UNUSED_FIRST)),
                CSR_DATA_W'($urandom_range(0, 65535)));
      csr_we <= 1'b0;
   endtask

   // Random frames: line-shaped patterns (narrow blobs, some of them
   // inverted), raw noise, crossings and lost line. Elapsed time mixes
   // short frames that keep a turn going with long ones that time it out.
   task automatic run_frames(input int count);
      logic [SENSOR_COUNT-1:0] line;
      logic [MS_W-1:0]         ms;
      int                      pick, width, pos;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            line = SENSOR_COUNT'($urandom_range(0, 127));
         end else if (pick < 75) begin
            width = $urandom_range(1, 3);
            pos   = $urandom_range(0, SENSOR_COUNT - width);
            line  = SENSOR_COUNT'(((1 << width) - 1) << pos);
            if ($urandom_range(0, 3) == 0)
               line = ~line;
         end else if (pick < 85) begin
            line = '0;
         end else begin
            line = 7'b0001000 | {1'($urandom_range(0, 1)), 5'b0,
                                 1'($urandom_range(0, 1))};
         end
         pick = $urandom_range(0, 9);
         if (pick < 5)
            ms = MS_W'($urandom_range(0, 255));
         else if (pick < 8)
            ms = MS_W'($urandom_range(0, 40));
         else
            ms = pick[0] ? 8'hFF : 8'h00;
         send_frame(line, ms);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed frames under reset defaults
      send_frame(7'b0000000, 8'd0);     // line lost from the start
      send_frame(7'b0001000, 8'd255);   // centred
      send_frame(7'b1111111, 8'd0);     // all set, flips to nothing seen
      send_frame(7'b0000100, 8'd1);     // small right error
      send_frame(7'b0010000, 8'd2);     // small left error, big derivative
      send_frame(7'b0000110, 8'd3);     // large error
      send_frame(7'b0000110, 8'd4);     // same again, zero derivative
      send_frame(7'b1110111, 8'd5);     // inverted frame, reads as centre
      send_frame(7'b0001001, 8'd6);     // crossing, right end
      send_frame(7'b1001000, 8'd7);     // crossing, left end
      send_frame(7'b1000000, 8'd8);     // sharp turn right starts
      send_frame(7'b0000000, 8'd255);   // turning
      send_frame(7'b0000000, 8'd255);   // turning
      send_frame(7'b0000000, 8'd255);   // timer passes 700, turn ends
      send_frame(7'b0000001, 8'd9);     // sharp turn left starts
      send_frame(7'b0000010, 8'd10);    // turning
      send_frame(7'b0001000, 8'd10);    // centre seen, turn ends
      send_frame(7'b0000011, 8'd11);    // spin right
      send_frame(7'b1100000, 8'd12);    // spin left
      repeat (5)
         send_frame(7'b0000111, 8'd128); // push the integral to its top
      repeat (10)
         send_frame(7'b1110000, 8'd64);  // and down to its floor

      load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 255),
                    $urandom_range(0, 255));
      run_frames(PHASE_FRAMES);

      load_settings(0, 0, 0, 0, 0);
      run_frames(PHASE_FRAMES);

      load_settings(65535, 65535, 65535, 255, 255);
      run_frames(PHASE_FRAMES);

      // mild gains, low speed above high speed
      load_settings($urandom_range(0, 4095), $urandom_range(0, 255),
                    $urandom_range(0, 4095), $urandom_range(180, 255),
                    $urandom_range(0, 100));
      run_frames(PHASE_FRAMES);

      load_settings(7168, 5, 9984, 120, 200);
      run_frames(PHASE_FRAMES);

      drain_words();
      if (board.mismatch_count == 0 && board.pending() == 0)
         $display("line_follower_pid_step_tb: clean");
      else
         $display("line_follower_pid_step_tb: errors");
      $finish;
   end

endmodule
